FILE: rtl/core/cic_force_interpolation_top_defines.svh
// ----------------------------------------------------------------------------
// cic force interpolation assertion macros
// shared property forms for the interpolation core checks
// ----------------------------------------------------------------------------
`ifndef CIC_FORCE_INTERPOLATION_TOP_DEFINES_SVH
`define CIC_FORCE_INTERPOLATION_TOP_DEFINES_SVH

// same-cycle implication, checked out of reset
`define CFI_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked out of reset
`define CFI_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/core/cfi_pkg.sv
// ----------------------------------------------------------------------------
// cfi_pkg
// constants and types shared by the interpolation core
// ----------------------------------------------------------------------------
package cfi_pkg;

    // grid edge, a power of two of at least 2 (parity banking needs it even)
    localparam int GRID_SIZE  = 32;
    localparam int GRID_BITS  = $clog2(GRID_SIZE);
    localparam int FRAC       = 16;
    localparam int POS_W      = 21;
    localparam int FORCE_W    = 32;
    localparam int IDX_W      = 15;
    localparam int FACT_W     = FRAC + 1;
    localparam int TERM_W     = FORCE_W + 1;
    localparam int PAIR_W     = TERM_W + 1;
    localparam int SUM_W      = TERM_W + 3;
    localparam int BANKS      = 8;
    localparam int BANK_AW    = 3 * (GRID_BITS - 1);
    localparam int BANK_DEPTH = 2 ** BANK_AW;

    localparam logic FUNC_WRITE = 1'b0;
    localparam logic FUNC_QUERY = 1'b1;

    typedef struct packed {
        logic [GRID_BITS-1:0] lo;
        logic [GRID_BITS-1:0] hi;
        logic [FRAC-1:0]      frac;
    } cfi_coord_t;

    typedef struct packed {
        logic signed [FORCE_W-1:0] z;
        logic signed [FORCE_W-1:0] y;
        logic signed [FORCE_W-1:0] x;
    } cfi_force_t;

endpackage

FILE: rtl/core/cfi_split.sv
// ----------------------------------------------------------------------------
// cfi_split
// shifts one coordinate back half a cell and splits it into cells and fraction
// ----------------------------------------------------------------------------
module cfi_split
    import cfi_pkg::*;
(
    input  logic [POS_W-1:0] pos,
    output cfi_coord_t       coord
);

    logic signed [POS_W:0] p;

    // arithmetic view: low cell bits of floor(p / 2^frac) wrap periodically,
    // a negative p gives all ones, i.e. the last cell
    assign p          = $signed({1'b0, pos}) - $signed((POS_W+1)'(1) <<< (FRAC - 1));
    assign coord.lo   = p[FRAC+GRID_BITS-1:FRAC];
    assign coord.hi   = coord.lo + GRID_BITS'(1);
    assign coord.frac = p[FRAC-1:0];

endmodule

FILE: rtl/core/cfi_bank.sv
// ----------------------------------------------------------------------------
// cfi_bank
// one parity bank of the three force grids, one write and one read port
// ----------------------------------------------------------------------------
module cfi_bank
    import cfi_pkg::*;
(
    input  logic               clk,
    input  logic               wr_en,
    input  logic [BANK_AW-1:0] wr_addr,
    input  cfi_force_t         wr_data,
    input  logic               rd_en,
    input  logic [BANK_AW-1:0] rd_addr,
    output cfi_force_t         rd_data
);

    cfi_force_t mem [BANK_DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

FILE: rtl/core/cfi_weights.sv
// ----------------------------------------------------------------------------
// cfi_weights
// two-stage trilinear weight products for the eight corners
// ----------------------------------------------------------------------------
module cfi_weights
    import cfi_pkg::*;
(
    input  logic              clk,
    input  logic              en,
    input  logic [FRAC-1:0]   dx,
    input  logic [FRAC-1:0]   dy,
    input  logic [FRAC-1:0]   dz,
    output logic [FACT_W-1:0] w [BANKS]
);

    logic [FACT_W-1:0]   fx [2];
    logic [FACT_W-1:0]   fy [2];
    logic [FACT_W-1:0]   fz_next [2];
    logic [FACT_W-1:0]   fz_reg [2];
    logic [FACT_W-1:0]   wxy_next [4];
    logic [FACT_W-1:0]   wxy_reg [4];
    logic [2*FACT_W-1:0] prod_xy [4];
    logic [2*FACT_W-1:0] prod_w [BANKS];

    localparam logic [FACT_W-1:0] ONE = FACT_W'(1) << FRAC;

    always_comb
    begin
        fx[0]      = ONE - {1'b0, dx};
        fx[1]      = {1'b0, dx};
        fy[0]      = ONE - {1'b0, dy};
        fy[1]      = {1'b0, dy};
        fz_next[0] = ONE - {1'b0, dz};
        fz_next[1] = {1'b0, dz};
        for (int n = 0; n < 4; n++)
        begin
            prod_xy[n]  = fx[n/2] * fy[n%2];
            // value never exceeds one, so the top product bit drops
            wxy_next[n] = prod_xy[n][FRAC+FACT_W-1:FRAC];
        end
        for (int n = 0; n < BANKS; n++)
        begin
            prod_w[n] = wxy_reg[n/2] * fz_reg[n%2];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            wxy_reg <= wxy_next;
            fz_reg  <= fz_next;
            for (int n = 0; n < BANKS; n++)
            begin
                w[n] <= prod_w[n][FRAC+FACT_W-1:FRAC];
            end
        end
    end

endmodule

FILE: rtl/core/cfi_accum.sv
// ----------------------------------------------------------------------------
// cfi_accum
// weighted corner terms, summing tree and saturation into the result register
// ----------------------------------------------------------------------------
module cfi_accum
    import cfi_pkg::*;
(
    input  logic                      clk,
    input  logic                      en,
    input  cfi_force_t                corner [BANKS],
    input  logic [FACT_W-1:0]         w [BANKS],
    output logic signed [FORCE_W-1:0] accel [3],
    output logic                      saturated
);

    localparam int PROD_W = FORCE_W + FACT_W + 1;
    localparam logic signed [SUM_W-1:0] MAX_V = SUM_W'((64'sd1 <<< (FORCE_W - 1)) - 1);
    localparam logic signed [SUM_W-1:0] MIN_V = -SUM_W'(64'sd1 <<< (FORCE_W - 1));

    logic signed [TERM_W-1:0] term_reg [3][BANKS];
    logic signed [PAIR_W-1:0] pair_reg [3][4];
    logic signed [PROD_W-1:0] prod;
    logic signed [TERM_W-1:0] term_next [3][BANKS];
    logic signed [SUM_W-1:0]  sum [3];
    logic signed [FORCE_W-1:0] accel_next [3];
    logic                     sat_next;
    logic signed [FORCE_W-1:0] f;

    always_comb
    begin
        prod = '0;
        f    = '0;
        for (int n = 0; n < BANKS; n++)
        begin
            for (int c = 0; c < 3; c++)
            begin
                f = (c == 0) ? corner[n].x : (c == 1) ? corner[n].y : corner[n].z;
                prod = f * $signed({1'b0, w[n]});
                // arithmetic shift floors toward minus infinity
                term_next[c][n] = prod[FRAC+TERM_W-1:FRAC];
            end
        end
        sat_next = 1'b0;
        for (int c = 0; c < 3; c++)
        begin
            sum[c] = SUM_W'(pair_reg[c][0]) + SUM_W'(pair_reg[c][1])
                   + SUM_W'(pair_reg[c][2]) + SUM_W'(pair_reg[c][3]);
            if (sum[c] > MAX_V)
            begin
                accel_next[c] = MAX_V[FORCE_W-1:0];
                sat_next      = 1'b1;
            end
            else if (sum[c] < MIN_V)
            begin
                accel_next[c] = MIN_V[FORCE_W-1:0];
                sat_next      = 1'b1;
            end
            else
            begin
                accel_next[c] = sum[c][FORCE_W-1:0];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            term_reg <= term_next;
            for (int c = 0; c < 3; c++)
            begin
                for (int q = 0; q < 4; q++)
                begin
                    pair_reg[c][q] <= PAIR_W'(term_reg[c][2*q]) + PAIR_W'(term_reg[c][2*q+1]);
                end
            end
            accel     <= accel_next;
            saturated <= sat_next;
        end
    end

endmodule

FILE: rtl/core/cic_force_interpolation_top.sv
// ----------------------------------------------------------------------------
// cic_force_interpolation_top
// cloud-in-cell trilinear force interpolation over three periodic grids
// ----------------------------------------------------------------------------
//  channel   dir  tdata                                       tuser
//  s_axis    in   cell_index, force x/y/z, pos x/y/z (176b)   func
//  m_axis    out  accel x/y/z, saturated (104b)               -
//
//  one request per cycle while no result is held; a query result leaves after
//  the stage 1 decode, the bank read, two weight products and the adder tree
//  eight parity banks (one per corner parity) deliver all corners in one read
//  grid contents are undefined after reset, no clearing pass
//  a held result stalls the whole pipeline, input ready follows that stall
`include "cic_force_interpolation_top_defines.svh"

module cic_force_interpolation_top
    import cfi_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // cell_index[14:0], cell_force_x[46:15], cell_force_y[78:47],
    // cell_force_z[110:79], pos_x[131:111], pos_y[152:132], pos_z[173:153]
    input  logic [175:0] s_axis_tdata,
    // func[0]
    input  logic [0:0]   s_axis_tuser,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // accel_x[31:0], accel_y[63:32], accel_z[95:64], saturated[96]
    output logic [103:0] m_axis_tdata
);

    // pipeline advance: everything moves when the result slot is free or taken
    logic adv;

    logic s1_vld_reg, s2_vld_reg, s3_vld_reg, s4_vld_reg, s5_vld_reg, out_vld_reg;

    // stage 1: decoded request
    logic             s1_func_reg;
    logic [IDX_W-1:0] s1_idx_reg;
    cfi_force_t       s1_force_reg;
    cfi_coord_t       s1_coord_reg [3];
    cfi_coord_t       coord_next [3];

    // stage 2: corner parity of the low cells
    logic [2:0]       s2_par_reg;

    // stage 3: bank data reordered by corner
    cfi_force_t       corner_reg [BANKS];

    cfi_force_t         bank_rd [BANKS];
    logic [BANK_AW-1:0] rd_addr [BANKS];
    logic [BANK_AW-1:0] wr_addr;
    logic [2:0]         wr_bank;
    logic [FACT_W-1:0]  w [BANKS];
    logic signed [FORCE_W-1:0] accel [3];
    logic               saturated;

    assign adv           = !out_vld_reg || m_axis_tready;
    assign s_axis_tready = adv;
    assign m_axis_tvalid = out_vld_reg;
    assign m_axis_tdata  = {7'd0, saturated, accel[2], accel[1], accel[0]};

    cfi_split u_split_x (.pos(s_axis_tdata[131:111]), .coord(coord_next[0]));
    cfi_split u_split_y (.pos(s_axis_tdata[152:132]), .coord(coord_next[1]));
    cfi_split u_split_z (.pos(s_axis_tdata[173:153]), .coord(coord_next[2]));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_vld_reg  <= 1'b0;
            s2_vld_reg  <= 1'b0;
            s3_vld_reg  <= 1'b0;
            s4_vld_reg  <= 1'b0;
            s5_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else if (adv)
        begin
            s1_vld_reg  <= s_axis_tvalid;
            // writes finish in stage 1 and leave no result behind
            s2_vld_reg  <= s1_vld_reg && (s1_func_reg == FUNC_QUERY);
            s3_vld_reg  <= s2_vld_reg;
            s4_vld_reg  <= s3_vld_reg;
            s5_vld_reg  <= s4_vld_reg;
            out_vld_reg <= s5_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_func_reg  <= s_axis_tuser[0];
            s1_idx_reg   <= s_axis_tdata[14:0];
            s1_force_reg <= s_axis_tdata[110:15];
            s1_coord_reg <= coord_next;
            s2_par_reg   <= {s1_coord_reg[0].lo[0], s1_coord_reg[1].lo[0],
                             s1_coord_reg[2].lo[0]};
            for (int n = 0; n < BANKS; n++)
            begin
                // corner n = {a,b,c}: bank parity is the low parity flipped by the offset
                corner_reg[n] <= bank_rd[s2_par_reg ^ 3'(n)];
            end
        end
    end

    // bank n = {i parity, j parity, k parity}; each bank is addressed by the
    // cell coordinates without their parity bit
    always_comb
    begin
        logic [GRID_BITS-1:0] sel [3];
        for (int n = 0; n < BANKS; n++)
        begin
            for (int d = 0; d < 3; d++)
            begin
                sel[d] = (s1_coord_reg[d].lo[0] == n[2-d]) ? s1_coord_reg[d].lo
                                                          : s1_coord_reg[d].hi;
            end
            rd_addr[n] = {sel[0][GRID_BITS-1:1], sel[1][GRID_BITS-1:1],
                          sel[2][GRID_BITS-1:1]};
        end
    end

    assign wr_bank = {s1_idx_reg[2*GRID_BITS], s1_idx_reg[GRID_BITS], s1_idx_reg[0]};
    assign wr_addr = {s1_idx_reg[3*GRID_BITS-1:2*GRID_BITS+1],
                      s1_idx_reg[2*GRID_BITS-1:GRID_BITS+1],
                      s1_idx_reg[GRID_BITS-1:1]};

    for (genvar n = 0; n < BANKS; n++)
    begin : g_bank
        cfi_bank u_bank (
            .clk     (clk),
            .wr_en   (adv && s1_vld_reg && (s1_func_reg == FUNC_WRITE)
                      && (wr_bank == 3'(n))),
            .wr_addr (wr_addr),
            .wr_data (s1_force_reg),
            .rd_en   (adv),
            .rd_addr (rd_addr[n]),
            .rd_data (bank_rd[n])
        );
    end

    cfi_weights u_weights (
        .clk (clk),
        .en  (adv),
        .dx  (s1_coord_reg[0].frac),
        .dy  (s1_coord_reg[1].frac),
        .dz  (s1_coord_reg[2].frac),
        .w   (w)
    );

    cfi_accum u_accum (
        .clk       (clk),
        .en        (adv),
        .corner    (corner_reg),
        .w         (w),
        .accel     (accel),
        .saturated (saturated)
    );

    // a held result must block new requests
    `CFI_ASSERT_IMP(a_stall_blocks, out_vld_reg && !m_axis_tready, !s_axis_tready, "accept during stall")
    // a write request never turns into a result
    `CFI_ASSERT_NEXT(a_write_silent, adv && s1_vld_reg && (s1_func_reg == FUNC_WRITE), !s2_vld_reg, "write made a result")
    // the clip flag comes with a component at a range limit
    `CFI_ASSERT_IMP(a_sat_limit, out_vld_reg && saturated, (accel[0] == 32'sh7fffffff) || (accel[0] == -32'sh80000000) || (accel[1] == 32'sh7fffffff) || (accel[1] == -32'sh80000000) || (accel[2] == 32'sh7fffffff) || (accel[2] == -32'sh80000000), "flag without clip")

endmodule
